// ===== rtl/crs_pkg.sv =====
//------------------------------------------------------------------------------
// crs_pkg
// Shared types and constants for the connection route search unit.
//------------------------------------------------------------------------------
`default_nettype none
package crs_pkg;

   localparam int MaxTicketsDefault = 16;
   localparam logic [31:0] CostMax = 32'hFFFF_FFFF;

   localparam logic [1:0] CsrStayTime    = 2'd0;
   localparam logic [1:0] CsrStartStation = 2'd1;
   localparam logic [1:0] CsrEndStation  = 2'd2;

   typedef struct packed {
      logic [7:0]  from_station;
      logic [7:0]  to_station;
      logic [31:0] depart_time;
      logic [31:0] arrive_time;
      logic [15:0] fare;
      logic        final_ticket;
   } req_type;

   typedef struct packed {
      logic       objective;
      logic       found;
      logic [3:0] ticket_slot;
      logic       route_end;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SEED,
      ST_RELAX,
      ST_PICK,
      ST_TRACE_START,
      ST_TRACE,
      ST_EMIT,
      ST_MISS,
      ST_NEXT
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/connection_route_search_unit.sv =====
//------------------------------------------------------------------------------
// connection_route_search_unit
// Loads tickets and searches earliest-arrival and cheapest routes.
//------------------------------------------------------------------------------
// Loading: one ticket per cycle, no response.
// Search after the final ticket, per objective: a seed pass, relax sweeps over
// all ticket pairs until one sweep changes nothing, a pick pass, a trace start
// and the traced legs, each result when the output is free, and a hand-over
// state; req_ready stays low throughout.
// Reset clears the ticket count, CSR and control registers and sequencer; no clearing pass.
//------------------------------------------------------------------------------
`default_nettype none
module connection_route_search_unit #(
   parameter int MAX_TICKETS = crs_pkg::MaxTicketsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire crs_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output crs_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_data
);
   localparam int IW = $clog2(MAX_TICKETS);
   localparam int CW = $clog2(MAX_TICKETS + 1);

   logic [15:0] stay_ff;
   logic [7:0]  start_ff, end_ff;

   logic [7:0]  from_ff [MAX_TICKETS];
   logic [7:0]  to_ff   [MAX_TICKETS];
   logic [31:0] dep_ff  [MAX_TICKETS];
   logic [31:0] arr_ff  [MAX_TICKETS];
   logic [15:0] fare_ff [MAX_TICKETS];
   logic [31:0] cost_ff [MAX_TICKETS];
   logic [MAX_TICKETS-1:0] reach_ff;
   logic [IW-1:0] stack_ff [MAX_TICKETS];

   crs_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] i_ff, j_ff, best_ff;
   logic [CW-1:0] len_ff;
   logic          have_ff, changed_ff, obj_ff;
   logic          out_valid_ff;
   crs_pkg::rsp_type out_ff;

   logic follows;
   logic [31:0] cand;
   logic last_i, last_j, accept, store;
   logic emit_slot;
   logic relax_hit;
   logic out_load;

   assign last_i = (CW'(i_ff) == count_ff - CW'(1));
   assign last_j = (CW'(j_ff) == count_ff - CW'(1));
   assign accept = req_valid && req_ready;
   assign store  = accept && (count_ff < CW'(MAX_TICKETS));

   crs_edge_unit u_edge (
      .stay_time  (stay_ff),
      .objective  (obj_ff),
      .src_to     (to_ff[i_ff]),
      .src_arrive (arr_ff[i_ff]),
      .src_cost   (cost_ff[i_ff]),
      .dst_from   (from_ff[j_ff]),
      .dst_depart (dep_ff[j_ff]),
      .dst_arrive (arr_ff[j_ff]),
      .dst_fare   (fare_ff[j_ff]),
      .follows    (follows),
      .cand_cost  (cand)
   );

   // Output slot free when empty or being taken.
   assign emit_slot = !out_valid_ff || rsp_ready;
   assign out_load  = emit_slot && (state_ff inside {crs_pkg::ST_EMIT, crs_pkg::ST_MISS});
   assign relax_hit = reach_ff[i_ff] && follows &&
                      (!reach_ff[j_ff] || cand < cost_ff[j_ff]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crs_pkg::ST_LOAD: begin
            if (accept && req_data.final_ticket) begin
               state_in = (count_ff == '0 && !store) ? crs_pkg::ST_PICK : crs_pkg::ST_SEED;
            end
         end
         crs_pkg::ST_SEED: begin
            if (last_j) state_in = crs_pkg::ST_RELAX;
         end
         crs_pkg::ST_RELAX: begin
            if (last_i && last_j && !changed_ff && !relax_hit) begin
               state_in = crs_pkg::ST_PICK;
            end
         end
         crs_pkg::ST_PICK: begin
            if (count_ff == '0 || last_i) begin
               state_in = crs_pkg::ST_TRACE_START;
            end
         end
         crs_pkg::ST_TRACE_START: begin
            state_in = crs_pkg::ST_TRACE;
         end
         crs_pkg::ST_TRACE: begin
            if (!have_ff) begin
               state_in = crs_pkg::ST_MISS;
            end else if (from_ff[j_ff] == start_ff) begin
               state_in = crs_pkg::ST_EMIT;
            end else if (reach_ff[i_ff] && follows && cand == cost_ff[j_ff]) begin
               if (len_ff >= CW'(MAX_TICKETS)) state_in = crs_pkg::ST_MISS;
            end else if (last_i) begin
               state_in = crs_pkg::ST_MISS;
            end
         end
         crs_pkg::ST_EMIT: begin
            if (emit_slot && len_ff == CW'(1)) state_in = crs_pkg::ST_NEXT;
         end
         crs_pkg::ST_MISS: begin
            if (emit_slot) state_in = crs_pkg::ST_NEXT;
         end
         crs_pkg::ST_NEXT: begin
            state_in = obj_ff ? crs_pkg::ST_LOAD : crs_pkg::ST_SEED;
            if (obj_ff == 1'b0 && count_ff == '0) state_in = crs_pkg::ST_PICK;
         end
         default: state_in = crs_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == crs_pkg::ST_LOAD);
      rsp_valid = out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crs_pkg::ST_LOAD;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         stay_ff      <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         obj_ff       <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         changed_ff   <= 1'b0;
         have_ff      <= 1'b0;
         len_ff       <= '0;
         reach_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (csr_index)
               crs_pkg::CsrStayTime:     stay_ff  <= csr_data;
               crs_pkg::CsrStartStation: start_ff <= csr_data[7:0];
               crs_pkg::CsrEndStation:   end_ff   <= csr_data[7:0];
               default: ;
            endcase
         end
         case (state_ff)
            crs_pkg::ST_LOAD: begin
               if (store) begin
                  from_ff[count_ff[IW-1:0]] <= req_data.from_station;
                  to_ff[count_ff[IW-1:0]]   <= req_data.to_station;
                  dep_ff[count_ff[IW-1:0]]  <= req_data.depart_time;
                  arr_ff[count_ff[IW-1:0]]  <= req_data.arrive_time;
                  fare_ff[count_ff[IW-1:0]] <= req_data.fare;
                  count_ff <= count_ff + CW'(1);
               end
               obj_ff <= 1'b0;
               i_ff   <= '0;
               j_ff   <= '0;
               have_ff <= 1'b0;
            end
            crs_pkg::ST_SEED: begin
               reach_ff[j_ff] <= (from_ff[j_ff] == start_ff);
               cost_ff[j_ff]  <= (from_ff[j_ff] != start_ff) ? crs_pkg::CostMax :
                                 obj_ff ? {16'd0, fare_ff[j_ff]} : arr_ff[j_ff];
               j_ff <= last_j ? '0 : j_ff + IW'(1);
               i_ff <= '0;
               changed_ff <= 1'b0;
            end
            crs_pkg::ST_RELAX: begin
               if (relax_hit) begin
                  reach_ff[j_ff] <= 1'b1;
                  cost_ff[j_ff]  <= cand;
               end
               changed_ff <= (last_i && last_j) ? 1'b0 : (changed_ff || relax_hit);
               j_ff <= last_j ? '0 : j_ff + IW'(1);
               if (last_j) begin
                  i_ff <= last_i ? '0 : i_ff + IW'(1);
               end
               have_ff <= 1'b0;
            end
            crs_pkg::ST_PICK: begin
               if (count_ff != '0 && start_ff != end_ff && reach_ff[i_ff] &&
                   to_ff[i_ff] == end_ff && (!have_ff || cost_ff[i_ff] < cost_ff[best_ff])) begin
                  have_ff <= 1'b1;
                  best_ff <= i_ff;
               end
               i_ff <= last_i ? '0 : i_ff + IW'(1);
            end
            crs_pkg::ST_TRACE_START: begin
               j_ff   <= best_ff;
               stack_ff[0] <= best_ff;
               len_ff <= CW'(1);
               i_ff   <= '0;
            end
            crs_pkg::ST_TRACE: begin
               if (have_ff && from_ff[j_ff] != start_ff) begin
                  if (reach_ff[i_ff] && follows && cand == cost_ff[j_ff]) begin
                     if (len_ff < CW'(MAX_TICKETS)) begin
                        stack_ff[len_ff[IW-1:0]] <= i_ff;
                        len_ff <= len_ff + CW'(1);
                        j_ff   <= i_ff;
                        i_ff   <= '0;
                     end
                  end else begin
                     i_ff <= i_ff + IW'(1);
                  end
               end
            end
            crs_pkg::ST_EMIT: begin
               if (emit_slot) begin
                  out_ff.objective      <= obj_ff;
                  out_ff.found          <= 1'b1;
                  out_ff.ticket_slot    <= 4'(stack_ff[len_ff[IW-1:0] - IW'(1)]);
                  out_ff.route_end      <= (len_ff == CW'(1));
                  len_ff <= len_ff - CW'(1);
               end
            end
            crs_pkg::ST_MISS: begin
               if (emit_slot) begin
                  out_ff.objective   <= obj_ff;
                  out_ff.found       <= 1'b0;
                  out_ff.ticket_slot <= '0;
                  out_ff.route_end   <= 1'b1;
               end
            end
            crs_pkg::ST_NEXT: begin
               i_ff    <= '0;
               j_ff    <= '0;
               have_ff <= 1'b0;
               if (obj_ff) count_ff <= '0;
               obj_ff  <= ~obj_ff;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/crs_edge_unit.sv =====
//------------------------------------------------------------------------------
// crs_edge_unit
// Shared evaluation of one ticket pair: follow test and candidate cost.
//------------------------------------------------------------------------------
`default_nettype none
module crs_edge_unit (
   input  wire logic [15:0] stay_time,
   input  wire logic        objective,
   input  wire logic [7:0]  src_to,
   input  wire logic [31:0] src_arrive,
   input  wire logic [31:0] src_cost,
   input  wire logic [7:0]  dst_from,
   input  wire logic [31:0] dst_depart,
   input  wire logic [31:0] dst_arrive,
   input  wire logic [15:0] dst_fare,
   output logic             follows,
   output logic [31:0]      cand_cost
);
   logic [32:0] ready_time;
   logic [32:0] fare_sum;

   always_comb begin
      ready_time = {1'b0, src_arrive} + {17'd0, stay_time};
      follows    = (src_to == dst_from) && (ready_time <= {1'b0, dst_depart});
      fare_sum   = {1'b0, src_cost} + {17'd0, dst_fare};
      if (!objective) begin
         cand_cost = dst_arrive;
      end else if (fare_sum[32]) begin
         cand_cost = crs_pkg::CostMax;
      end else begin
         cand_cost = fare_sum[31:0];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/crs_checker.sv =====
//------------------------------------------------------------------------------
// crs_checker
// Port-level checks for the connection route search unit.
//------------------------------------------------------------------------------
`default_nettype none
module crs_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire crs_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire crs_pkg::rsp_type rsp_data
);
   a_busy_after_final: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.final_ticket |=> !req_ready)
      else $error("ready after final transaction");
   a_no_rsp_while_loading: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(rsp_valid && $rose(rsp_valid)))
      else $error("response while loading");
   a_miss_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.route_end && rsp_data.ticket_slot == 4'd0)
      else $error("not-found transaction malformed");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");
endmodule

bind connection_route_search_unit crs_checker u_crs_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);
`default_nettype wire

// ===== tb/connection_route_search_unit_tb.sv =====
//------------------------------------------------------------------------------
// connection_route_search_unit_tb
// Self-checking bench for the route search unit. It loads ticket sets and
// compares each route leg with its own model of the earliest-arrival and
// cheapest searches. A directed plan comes first, then random ticket sets
// under several station and stay-time settings, with random idling on both
// sides.
//------------------------------------------------------------------------------
`default_nettype none
module connection_route_search_unit_tb;

   localparam int Slots      = crs_pkg::MaxTicketsDefault;
   localparam int StallLimit = 60000;

   typedef struct {
      bit               is_cfg;
      logic [1:0]       idx;
      logic [15:0]      val;
      crs_pkg::req_type ticket;
      bit               typed;
   } plan_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   crs_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   crs_pkg::rsp_type rsp_data;
   logic             csr_write;
   logic [1:0]       csr_index;
   logic [15:0]      csr_data;

   // model state
   logic [7:0]  m_from [Slots];
   logic [7:0]  m_to [Slots];
   logic [31:0] m_depart [Slots];
   logic [31:0] m_arrive [Slots];
   logic [15:0] m_fare [Slots];
   int          m_count;
   logic [15:0] m_stay;
   logic [7:0]  m_start;
   logic [7:0]  m_end;

   crs_pkg::rsp_type route_legs[$];
   crs_pkg::rsp_type search_out[$];
   plan_row_type     plan[$];
   int               failures;
   int               stall_cycles;
   int               idle_mode;
   int               items_sent;

   connection_route_search_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic bit may_follow(int i, int j);
      logic [32:0] ready_at;
      ready_at = {1'b0, m_arrive[i]} + {17'd0, m_stay};
      return m_to[i] == m_from[j] && ready_at <= {1'b0, m_depart[j]};
   endfunction

   function automatic logic [31:0] leg_cost(bit obj, logic [31:0] prev, int j);
      logic [32:0] sum;
      if (!obj)
         return m_arrive[j];
      sum = {1'b0, prev} + {17'd0, m_fare[j]};
      return sum[32] ? crs_pkg::CostMax : sum[31:0];
   endfunction

   function automatic void search_objective(bit obj);
      logic [31:0]      cost [Slots];
      bit               reach [Slots];
      int               stack [Slots];
      int               len;
      int               best;
      int               cur;
      int               i;
      bit               have;
      bit               changed;
      bit               hit;
      logic [31:0]      c;
      crs_pkg::rsp_type r;
      have = 0;
      best = 0;
      len  = 0;
      for (i = 0; i < m_count; i++) begin
         reach[i] = m_from[i] == m_start;
         cost[i]  = reach[i] ? leg_cost(obj, 32'd0, i) : crs_pkg::CostMax;
      end
      do begin
         changed = 0;
         for (i = 0; i < m_count; i++) begin
            if (!reach[i])
               continue;
            for (int j = 0; j < m_count; j++) begin
               if (!may_follow(i, j))
                  continue;
               c = leg_cost(obj, cost[i], j);
               if (!reach[j] || c < cost[j]) begin
                  reach[j] = 1;
                  cost[j]  = c;
                  changed  = 1;
               end
            end
         end
      end while (changed);
      if (m_start != m_end) begin
         for (i = 0; i < m_count; i++)
            if (reach[i] && m_to[i] == m_end && (!have || cost[i] < cost[best])) begin
               have = 1;
               best = i;
            end
      end
      if (have) begin
         cur = best;
         stack[len++] = cur;
         while (m_from[cur] != m_start) begin
            hit = 0;
            for (i = 0; i < m_count; i++)
               if (reach[i] && may_follow(i, cur) &&
                   leg_cost(obj, cost[i], cur) == cost[cur]) begin
                  hit = 1;
                  break;
               end
            if (!hit || len >= Slots) begin
               have = 0;
               break;
            end
            cur = i;
            stack[len++] = cur;
         end
      end
      if (!have) begin
         r = '{objective: obj, found: 1'b0, ticket_slot: 4'd0, route_end: 1'b1};
         search_out = {search_out, r};
         return;
      end
      for (int k = 0; k < len; k++) begin
         r.objective   = obj;
         r.found       = 1'b1;
         r.ticket_slot = stack[len - 1 - k][3:0];
         r.route_end   = (k == len - 1);
         search_out = {search_out, r};
      end
   endfunction

   function automatic void load_ticket(crs_pkg::req_type t);
      search_out.delete();
      if (m_count < Slots) begin
         m_from[m_count]   = t.from_station;
         m_to[m_count]     = t.to_station;
         m_depart[m_count] = t.depart_time;
         m_arrive[m_count] = t.arrive_time;
         m_fare[m_count]   = t.fare;
         m_count++;
      end
      if (t.final_ticket) begin
         search_objective(1'b0);
         search_objective(1'b1);
         m_count = 0;
      end
   endfunction

   task automatic send_ticket(crs_pkg::req_type t, bit typed);
      crs_pkg::rsp_type nf;
      int               gap;
      req_data  <= t;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      load_ticket(t);
      if (typed) begin
         if (t.final_ticket) begin
            for (int k = 0; k < 2; k++) begin
               nf = '{objective: k[0], found: 1'b0, ticket_slot: 4'd0, route_end: 1'b1};
               route_legs = {route_legs, nf};
            end
         end
      end else begin
         foreach (search_out[k])
            route_legs = {route_legs, search_out[k]};
      end
      items_sent++;
      gap = 0;
      if (idle_mode == 0 && $urandom_range(99) < 33)
         gap = $urandom_range(1, 5);
      if (idle_mode == 1 && $urandom_range(99) < 68)
         gap = $urandom_range(1, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (route_legs.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         crs_pkg::CsrStayTime:     m_stay  = val;
         crs_pkg::CsrStartStation: m_start = val[7:0];
         crs_pkg::CsrEndStation:   m_end   = val[7:0];
         default: ;
      endcase
   endtask

   function automatic crs_pkg::req_type mk(logic [7:0] f, logic [7:0] t, logic [31:0] d,
                                           logic [31:0] a, logic [15:0] p, bit fin);
      crs_pkg::req_type r;
      r.from_station = f;
      r.to_station   = t;
      r.depart_time  = d;
      r.arrive_time  = a;
      r.fare         = p;
      r.final_ticket = fin;
      return r;
   endfunction

   function automatic void add_cfg(logic [1:0] idx, logic [15:0] val);
      plan_row_type p;
      p.is_cfg = 1;
      p.idx    = idx;
      p.val    = val;
      p.ticket = '0;
      p.typed  = 0;
      plan = {plan, p};
   endfunction

   function automatic void add_ticket(crs_pkg::req_type t, bit typed);
      plan_row_type p;
      p.is_cfg = 0;
      p.idx    = crs_pkg::CsrStayTime;
      p.val    = '0;
      p.ticket = t;
      p.typed  = typed;
      plan = {plan, p};
   endfunction

   function automatic crs_pkg::req_type random_ticket(bit fin);
      crs_pkg::req_type t;
      logic [31:0]      d;
      if ($urandom_range(9) == 0) begin
         t = mk(8'($urandom), 8'($urandom), $urandom, $urandom, 16'($urandom), fin);
      end else begin
         d = $urandom_range(0, 300);
         t = mk(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), d,
                d + $urandom_range(0, 60), 16'($urandom_range(0, 200)), fin);
      end
      return t;
   endfunction

   // response side, stall control and watchdog
   always @(posedge clock) begin
      crs_pkg::rsp_type exp_leg;
      if (reset) begin
         rsp_ready    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         case (idle_mode)
            0:       rsp_ready <= $urandom_range(99) >= 68;
            1:       rsp_ready <= $urandom_range(99) >= 33;
            default: rsp_ready <= 1'b1;
         endcase
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= StallLimit) begin
            $display("connection_route_search_unit_tb: FAIL");
            $finish;
         end else if (rsp_valid && rsp_ready) begin
            if (route_legs.size() == 0) begin
               $error("unexpected transaction %p", rsp_data);
               failures++;
            end else begin
               exp_leg = route_legs.pop_front();
               if (rsp_data.objective !== exp_leg.objective) begin
                  $error("objective exp %0d got %0d", exp_leg.objective, rsp_data.objective);
                  failures++;
               end
               if (rsp_data.found !== exp_leg.found) begin
                  $error("found exp %0d got %0d", exp_leg.found, rsp_data.found);
                  failures++;
               end
               if (rsp_data.ticket_slot !== exp_leg.ticket_slot) begin
                  $error("ticket_slot exp %0d got %0d", exp_leg.ticket_slot,
                         rsp_data.ticket_slot);
                  failures++;
               end
               if (rsp_data.route_end !== exp_leg.route_end) begin
                  $error("route_end exp %0d got %0d", exp_leg.route_end, rsp_data.route_end);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      int set_len;
      int quota;
      failures   = 0;
      items_sent = 0;
      idle_mode  = 2;
      m_count    = 0;
      m_stay     = '0;
      m_start    = '0;
      m_end      = '0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_write  = 1'b0;
      csr_index  = crs_pkg::CsrStayTime;
      csr_data   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // start equals end after reset: both objectives miss
      add_ticket(mk(8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1), 1);
      add_ticket(mk(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0), 1);
      add_ticket(mk(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1), 1);
      add_ticket(mk(8'h00, 8'h01, 32'h5, 32'h9, 16'h3, 1'b1), 1);
      // two-leg route against a slow but cheap direct ticket, plus an unreachable one
      add_cfg(crs_pkg::CsrStayTime, 16'd5);
      add_cfg(crs_pkg::CsrStartStation, 16'd1);
      add_cfg(crs_pkg::CsrEndStation, 16'd2);
      add_ticket(mk(8'd1, 8'd3, 32'd10, 32'd20, 16'd100, 1'b0), 0);
      add_ticket(mk(8'd3, 8'd2, 32'd25, 32'd40, 16'd50, 1'b0), 0);
      add_ticket(mk(8'd1, 8'd2, 32'd10, 32'd60, 16'd30, 1'b0), 0);
      add_ticket(mk(8'd7, 8'd2, 32'd0, 32'd5, 16'd1, 1'b0), 0);
      add_ticket(mk(8'd3, 8'd2, 32'd24, 32'd30, 16'd900, 1'b1), 0);
      // transfer too tight, then no route at all
      add_ticket(mk(8'd1, 8'd3, 32'd0, 32'd10, 16'd1, 1'b0), 0);
      add_ticket(mk(8'd3, 8'd2, 32'd14, 32'd20, 16'd1, 1'b1), 0);
      add_ticket(mk(8'd4, 8'd5, 32'd0, 32'd1, 16'd1, 1'b1), 0);
      // widest stay and station extremes, arrival overflow past the top
      add_cfg(crs_pkg::CsrStayTime, 16'hFFFF);
      add_cfg(crs_pkg::CsrStartStation, 16'h00FF);
      add_cfg(crs_pkg::CsrEndStation, 16'h0000);
      add_ticket(mk(8'hFF, 8'h00, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0), 0);
      add_ticket(mk(8'h00, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 1'b0), 0);
      add_ticket(mk(8'hFF, 8'hFF, 32'h0, 32'h10, 16'h0, 1'b0), 0);
      add_ticket(mk(8'hFF, 8'h00, 32'h1_0010, 32'h1_0020, 16'h1, 1'b1), 0);

      foreach (plan[k]) begin
         if (plan[k].is_cfg) begin
            drain();
            write_csr(plan[k].idx, plan[k].val);
         end else
            send_ticket(plan[k].ticket, plan[k].typed);
      end

      for (int mode = 0; mode < 3; mode++) begin
         idle_mode = mode;
         quota     = items_sent + 110;
         while (items_sent < quota) begin
            drain();
            case ($urandom_range(0, 5))
               0:       write_csr(crs_pkg::CsrStayTime, 16'd0);
               1:       write_csr(crs_pkg::CsrStayTime, 16'hFFFF);
               default: write_csr(crs_pkg::CsrStayTime, 16'($urandom_range(0, 20)));
            endcase
            write_csr(crs_pkg::CsrStartStation, ($urandom_range(0, 7) == 0) ? 16'hFF
                                                : 16'($urandom_range(0, 3)));
            write_csr(crs_pkg::CsrEndStation, ($urandom_range(0, 7) == 0) ? 16'hFF
                                              : 16'($urandom_range(0, 3)));
            repeat ($urandom_range(2, 4)) begin
               set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                     : $urandom_range(1, 6);
               for (int n = 0; n < set_len; n++)
                  send_ticket(random_ticket(n == set_len - 1), 0);
            end
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (failures == 0 && route_legs.size() == 0)
         $display("connection_route_search_unit_tb: PASS");
      else
         $display("connection_route_search_unit_tb: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

// ===== connection_route_search_unit.f =====
rtl/crs_pkg.sv
rtl/crs_edge_unit.sv
rtl/connection_route_search_unit.sv
rtl/crs_checker.sv
tb/connection_route_search_unit_tb.sv
